// File: hdl/pt100_pkg.sv
// ----------------------------------------------------------------------------
// pt100_pkg
// Shared codes, register indexes and control structs for the pt100 unit.
// ----------------------------------------------------------------------------
package pt100_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_CAL_ONE   = 3'd0;
   localparam logic [2:0] REG_CAL_TWO   = 3'd1;
   localparam logic [2:0] REG_CAL_THREE = 3'd2;
   localparam logic [2:0] REG_QUAD_A    = 3'd3;
   localparam logic [2:0] REG_LIN_B     = 3'd4;
   localparam logic [2:0] REG_CONST_C   = 3'd5;

   // result status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_BANDGAP = 2'd1;
   localparam logic [1:0] STS_EXTREME = 2'd2;
   localparam logic [1:0] STS_NO_ROOT = 2'd3;

   // coefficient reset values
   localparam logic [31:0] RST_QUAD_A  = 32'hFFFC_3718;
   localparam logic [23:0] RST_LIN_B   = 24'd6556985;
   localparam logic [24:0] RST_CONST_C = 25'd6553600;

   // reading limits
   localparam logic [9:0]  BANDGAP_MIN = 10'd550;
   localparam logic [9:0]  BANDGAP_MAX = 10'd700;
   localparam logic [9:0]  QUICK_MIN   = 10'd5;
   localparam logic [9:0]  QUICK_MAX   = 10'd1018;
   localparam logic [10:0] SUM_MIN     = 11'd10;
   localparam logic [10:0] SUM_MAX     = 11'd2036;

   // iteration counts, minus one
   localparam logic [4:0] SQRT_LAST = 5'd31;
   localparam logic [4:0] DIV_LAST  = 5'd18;

   typedef struct packed {
      logic load_in;
      logic check;
      logic mul_lo;
      logic mul_hi;
      logic disc;
      logic sqrt_step;
      logic prep_num;
      logic prep_div;
      logic div_step;
      logic finish;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic early_exit;
      logic disc_fail;
   } sts_type;

endpackage

// File: hdl/pt100_autorange_temperature_unit.sv
// ----------------------------------------------------------------------------
// pt100_autorange_temperature_unit
// Probe temperature from bandgap, quick and averaged readings with range
// switching and quadratic inversion.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per measurement (probe select and three readings).
//   rsp_*  : one beat per request: temperature in 1/256 degree, status and
//            the range flag after the measurement.
//   csr_*  : register writes, always ready; write only while idle.
// Flow: bandgap and extreme-reading errors leave after the check, a missing
//   root after the discriminant, a full conversion after the square root and
//   the divider: the 32-step square root and the 19-step restoring divider
//   share one sequencer. One request is in work at a time, so a new request
//   is taken only once the last one has left the sequencer.
// Stall: the result sits in an output register; a new request is taken
//   while it waits, and the next result waits in the sequencer until the
//   output register is free.
// Reset: coefficients return to their defaults, calibrations to zero, the
//   range flag to low range, no result is pending.
// ----------------------------------------------------------------------------
module pt100_autorange_temperature_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_probe_select,
   input  logic [9:0]         req_bandgap_reading,
   input  logic [9:0]         req_quick_reading,
   input  logic [10:0]        req_reading_sum,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [18:0] rsp_temperature,
   output logic [1:0]         rsp_status,
   output logic               rsp_range_low,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [59:0]        csr_wdata
);
   import pt100_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   // sequencer
   pt100_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // arithmetic
   pt100_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_probe_select    (req_probe_select),
      .req_bandgap_reading (req_bandgap_reading),
      .req_quick_reading   (req_quick_reading),
      .req_reading_sum     (req_reading_sum),
      .rsp_temperature     (rsp_temperature),
      .rsp_status          (rsp_status),
      .rsp_range_low       (rsp_range_low)
   );

endmodule

// File: hdl/pt100_ctrl.sv
// ----------------------------------------------------------------------------
// pt100_ctrl
// Sequencer: steps the datapath through check, multiply, root and divide,
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module pt100_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pt100_pkg::cmd_type cmd,
   input  pt100_pkg::sts_type sts
);
   import pt100_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_MULLO = 4'd2;
   localparam logic [3:0] S_MULHI = 4'd3;
   localparam logic [3:0] S_DISC  = 4'd4;
   localparam logic [3:0] S_SQRT  = 4'd5;
   localparam logic [3:0] S_PREPN = 4'd6;
   localparam logic [3:0] S_PREPD = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.early_exit ? S_DONE : S_MULLO;
         end
         S_MULLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MULHI;
         end
         S_MULHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_DISC;
         end
         S_DISC: begin
            cmd.disc = 1'b1;
            cnt_in   = SQRT_LAST;
            state_in = sts.disc_fail ? S_DONE : S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - 5'd1;
            if (cnt_ff == '0) state_in = S_PREPN;
         end
         S_PREPN: begin
            cmd.prep_num = 1'b1;
            state_in     = S_PREPD;
         end
         S_PREPD: begin
            cmd.prep_div = 1'b1;
            cnt_in       = DIV_LAST;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 5'd1;
            if (cnt_ff == '0) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output beat holds until taken
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/pt100_dpath.sv
// ----------------------------------------------------------------------------
// pt100_dpath
// Datapath: coefficient registers, range flag, resistance and discriminant,
// bit-serial square root, restoring divider and the output register.
// ----------------------------------------------------------------------------
module pt100_dpath (
   input  logic                clock,
   input  logic                reset,
   input  pt100_pkg::cmd_type  cmd,
   output pt100_pkg::sts_type  sts,
   input  logic                csr_valid,
   input  logic [2:0]          csr_index,
   input  logic [59:0]         csr_wdata,
   input  logic [1:0]          req_probe_select,
   input  logic [9:0]          req_bandgap_reading,
   input  logic [9:0]          req_quick_reading,
   input  logic [10:0]         req_reading_sum,
   output logic signed [18:0]  rsp_temperature,
   output logic [1:0]          rsp_status,
   output logic                rsp_range_low
);
   import pt100_pkg::*;

   // configuration
   logic [59:0] cal_one_ff, cal_two_ff, cal_three_ff;
   logic [31:0] a_ff;
   logic [23:0] b_ff;
   logic [24:0] c_ff;
   logic        flag_ff;

   // captured item
   logic [1:0]  sel_ff;
   logic [9:0]  bg_ff, quick_ff;
   logic [10:0] sum_ff;

   // working registers
   logic [1:0]         status_ff, status_in;
   logic               flag_in;
   logic signed [34:0] rc_ff, rc_in;
   logic signed [49:0] plo_ff, plo_in, phi_ff, phi_in;
   logic [47:0]        bb_ff, bb_in;
   logic [63:0]        v_ff;
   logic [35:0]        rem_ff;
   logic [31:0]        root_ff;
   logic [48:0]        n_ff, n_in, drem_ff;
   logic [32:0]        d_ff, d_in;
   logic               neg_ff, neg_in, sat_ff;
   logic [50:0]        dsh_ff;
   logic [18:0]        quo_ff;
   logic signed [18:0] temp_ff, temp_in;

   // range decision and resistance
   logic               bg_bad, quick_ext, sum_bad;
   logic [59:0]        cal_sel;
   logic [19:0]        offset;
   logic [30:0]        prod_fs;
   logic signed [34:0] r_val, c8;

   always_comb begin
      bg_bad    = (bg_ff < BANDGAP_MIN) || (bg_ff > BANDGAP_MAX);
      quick_ext = (quick_ff < QUICK_MIN) || (quick_ff > QUICK_MAX);
      sum_bad   = (sel_ff == 2'd3) || (sum_ff < SUM_MIN) || (sum_ff > SUM_MAX);
      flag_in   = bg_bad ? flag_ff : (flag_ff ^ quick_ext);
      case (sel_ff)
         2'd0:    cal_sel = cal_one_ff;
         2'd1:    cal_sel = cal_two_ff;
         2'd2:    cal_sel = cal_three_ff;
         default: cal_sel = cal_one_ff;
      endcase
      offset  = flag_in ? cal_sel[39:20] : cal_sel[59:40];
      prod_fs = cal_sel[19:0] * sum_ff;
      r_val   = $signed({4'b0, prod_fs}) + $signed({{7{offset[19]}}, offset, 8'b0});
      c8      = $signed({7'b0, c_ff, 3'b0});
      rc_in   = r_val - c8;
      if (bg_bad)       status_in = STS_BANDGAP;
      else if (sum_bad) status_in = STS_EXTREME;
      else              status_in = STS_OK;
   end

   assign sts.early_exit = bg_bad || sum_bad;

   // partial products of the discriminant
   assign plo_in = $signed(a_ff) * $signed({1'b0, rc_ff[16:0]});
   assign phi_in = $signed(a_ff) * $signed(rc_ff[34:17]);
   assign bb_in  = b_ff * b_ff;

   logic signed [67:0] d_sum;
   assign d_sum = $signed({19'b0, bb_ff, 1'b0})
                + $signed({{18{plo_ff[49]}}, plo_ff})
                + $signed({phi_ff[49], phi_ff, 17'b0});
   assign sts.disc_fail = (a_ff == '0) || d_sum[67];

   // one root bit per step
   logic [35:0] rem_sh, trial;
   logic        sq_ge;
   assign rem_sh = {rem_ff[33:0], v_ff[63:62]};
   assign trial  = {2'b0, root_ff, 2'b01};
   assign sq_ge  = rem_sh >= trial;

   // numerator and divisor magnitudes
   logic signed [33:0] num;
   logic [32:0]        mn;
   logic [31:0]        ma;
   always_comb begin
      num    = $signed({2'b0, root_ff}) - $signed({9'b0, b_ff, 1'b0});
      mn     = num[33] ? 33'(-num) : num[32:0];
      ma     = a_ff[31] ? (32'd0 - a_ff) : a_ff;
      n_in   = {1'b0, mn, 15'b0} + {17'b0, ma};
      d_in   = {ma, 1'b0};
      neg_in = num[33] ^ a_ff[31];
   end

   // one quotient bit per step
   logic dv_ge;
   assign dv_ge = {2'b0, drem_ff} >= dsh_ff;

   // sign and saturate the rounded quotient
   always_comb begin
      if (neg_ff) begin
         if (sat_ff || quo_ff > 19'd262144) temp_in = 19'sh40000;
         else                                temp_in = 19'(-$signed({1'b0, quo_ff}));
      end else begin
         if (sat_ff || quo_ff > 19'd262143) temp_in = 19'sh3FFFF;
         else                                temp_in = $signed(quo_ff);
      end
   end

   // control state: coefficients and range flag
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_one_ff   <= '0;
         cal_two_ff   <= '0;
         cal_three_ff <= '0;
         a_ff         <= RST_QUAD_A;
         b_ff         <= RST_LIN_B;
         c_ff         <= RST_CONST_C;
         flag_ff      <= 1'b1;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_CAL_ONE:   cal_one_ff   <= csr_wdata;
               REG_CAL_TWO:   cal_two_ff   <= csr_wdata;
               REG_CAL_THREE: cal_three_ff <= csr_wdata;
               REG_QUAD_A:    a_ff         <= csr_wdata[31:0];
               REG_LIN_B:     b_ff         <= csr_wdata[23:0];
               REG_CONST_C:   c_ff         <= csr_wdata[24:0];
               default:       ;
            endcase
         end
         if (cmd.check) flag_ff <= flag_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         sel_ff   <= req_probe_select;
         bg_ff    <= req_bandgap_reading;
         quick_ff <= req_quick_reading;
         sum_ff   <= req_reading_sum;
      end
      if (cmd.check) begin
         status_ff <= status_in;
         rc_ff     <= rc_in;
         temp_ff   <= '0;
      end
      if (cmd.mul_lo) begin
         plo_ff <= plo_in;
         bb_ff  <= bb_in;
      end
      if (cmd.mul_hi) phi_ff <= phi_in;
      if (cmd.disc) begin
         if (sts.disc_fail) status_ff <= STS_NO_ROOT;
         v_ff    <= {d_sum[62:0], 1'b0};
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         v_ff    <= {v_ff[61:0], 2'b00};
         rem_ff  <= sq_ge ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[30:0], sq_ge};
      end
      if (cmd.prep_num) begin
         n_ff   <= n_in;
         d_ff   <= d_in;
         neg_ff <= neg_in;
      end
      if (cmd.prep_div) begin
         sat_ff  <= {3'b0, n_ff} >= {d_ff, 19'b0};
         dsh_ff  <= {d_ff, 18'b0};
         drem_ff <= n_ff;
         quo_ff  <= '0;
      end
      if (cmd.div_step) begin
         if (dv_ge) drem_ff <= drem_ff - dsh_ff[48:0];
         dsh_ff <= {1'b0, dsh_ff[50:1]};
         quo_ff <= {quo_ff[17:0], dv_ge};
      end
      if (cmd.finish) temp_ff <= temp_in;
      if (cmd.load_out) begin
         rsp_temperature <= (status_ff == STS_OK) ? temp_ff : '0;
         rsp_status      <= status_ff;
         rsp_range_low   <= flag_ff;
      end
   end

endmodule

// File: hdl/pt100_checker.sv
// ----------------------------------------------------------------------------
// pt100_checker
// Port-level checks of the pt100 unit, bound to the top level.
// ----------------------------------------------------------------------------
module pt100_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [18:0] rsp_temperature,
   input logic [1:0]         rsp_status
);
   import pt100_pkg::*;

   // stalled result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature)
                                  && $stable(rsp_status))
      else $error("result changed while stalled");

   // no result straight out of reset
   a_rst_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");

   // error results carry zero temperature
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |-> rsp_temperature == '0)
      else $error("nonzero temperature with error status");

   // one item in work at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind pt100_autorange_temperature_unit pt100_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_temperature (rsp_temperature),
   .rsp_status      (rsp_status)
);
